@@ sv/slcd_pkg.sv @@
// ----------------------------------------------------------------------------
// slcd_pkg
// Types and constants shared by the packet deframer's controller, datapath
// and top level, and the CRC-16/CCITT byte update used by the datapath.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int CRC_W   = 16;
    localparam int TICK_W  = 16;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;

    localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'hFFFF;

    typedef enum logic [CFG_AW-1:0] {
        REG_SYNC_0     = 3'd0,
        REG_SYNC_1     = 3'd1,
        REG_SYNC_2     = 3'd2,
        REG_SYNC_3     = 3'd3,
        REG_TERMINATOR = 3'd4,
        REG_TIMEOUT    = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ERR_SYNC   = 2'd0,
        ERR_LENGTH = 2'd1,
        ERR_CRC    = 2'd2,
        ERR_TERM   = 2'd3
    } err_code_t;

    typedef struct packed {
        logic      tick;
        logic      frame_reset;
        logic      load_len;
        logic      store_byte;
        logic      load_crc_hi;
        logic      err_load;
        err_code_t err_code;
        logic      emit_start;
        logic      emit_read;
        logic      emit_load;
    } slcd_cmd_t;

    typedef struct packed {
        logic sync0_match;
        logic sync1_match;
        logic sync2_match;
        logic sync3_match;
        logic term_match;
        logic len_ok;
        logic crc_ok;
        logic pay_last;
        logic timeout_hit;
        logic emit_last;
        logic out_free;
    } slcd_status_t;

    function automatic logic [CRC_W-1:0] crc_update(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] x;
        x = crc[15:8] ^ b;
        x = x ^ (x >> 4);
        return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
               ^ {8'h00, x};
    endfunction

endpackage

@@ sv/slcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// slcd_ctrl
// Frame state machine: walks sync, length, payload, CRC and terminator
// phases, then sequences delivery of a good frame's payload.
// ----------------------------------------------------------------------------
module slcd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  slcd_pkg::slcd_status_t status,
    output slcd_pkg::slcd_cmd_t    cmd
);
    import slcd_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_SYNC1   = 11'b000_0000_0010,
        ST_SYNC2   = 11'b000_0000_0100,
        ST_SYNC3   = 11'b000_0000_1000,
        ST_LEN     = 11'b000_0001_0000,
        ST_PAY     = 11'b000_0010_0000,
        ST_CRC1    = 11'b000_0100_0000,
        ST_CRC2    = 11'b000_1000_0000,
        ST_TERM    = 11'b001_0000_0000,
        ST_EMIT_RD = 11'b010_0000_0000,
        ST_EMIT_WR = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   emitting;
    logic   accept;

    assign emitting = (state_reg == ST_EMIT_RD) || (state_reg == ST_EMIT_WR);
    assign in_ready = !emitting && status.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        if (accept && mode)
        begin
            cmd.tick = 1'b1;
            if (status.timeout_hit)
            begin
                cmd.frame_reset = 1'b1;
                state_next      = ST_IDLE;
            end
        end
        else if (accept)
        begin
            case (state_reg)
                ST_SYNC1:
                begin
                    if (!status.sync1_match)
                    begin
                        cmd.err_load    = 1'b1;
                        cmd.err_code    = ERR_SYNC;
                        cmd.frame_reset = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SYNC2;
                    end
                end
                ST_SYNC2:
                begin
                    if (!status.sync2_match)
                    begin
                        cmd.err_load    = 1'b1;
                        cmd.err_code    = ERR_SYNC;
                        cmd.frame_reset = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SYNC3;
                    end
                end
                ST_SYNC3:
                begin
                    if (!status.sync3_match)
                    begin
                        cmd.err_load    = 1'b1;
                        cmd.err_code    = ERR_SYNC;
                        cmd.frame_reset = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_LEN;
                    end
                end
                ST_LEN:
                begin
                    if (!status.len_ok)
                    begin
                        cmd.err_load    = 1'b1;
                        cmd.err_code    = ERR_LENGTH;
                        cmd.frame_reset = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        cmd.load_len = 1'b1;
                        state_next   = ST_PAY;
                    end
                end
                ST_PAY:
                begin
                    cmd.store_byte = 1'b1;
                    if (status.pay_last)
                    begin
                        state_next = ST_CRC1;
                    end
                end
                ST_CRC1:
                begin
                    cmd.load_crc_hi = 1'b1;
                    state_next      = ST_CRC2;
                end
                ST_CRC2:
                begin
                    if (!status.crc_ok)
                    begin
                        cmd.err_load    = 1'b1;
                        cmd.err_code    = ERR_CRC;
                        cmd.frame_reset = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_TERM;
                    end
                end
                ST_TERM:
                begin
                    cmd.frame_reset = 1'b1;
                    if (!status.term_match)
                    begin
                        cmd.err_load = 1'b1;
                        cmd.err_code = ERR_TERM;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_EMIT_RD;
                    end
                end
                default:
                begin
                    state_next = status.sync0_match ? ST_SYNC1 : ST_IDLE;
                end
            endcase
        end
        else if (state_reg == ST_EMIT_RD)
        begin
            cmd.emit_read = 1'b1;
            state_next    = ST_EMIT_WR;
        end
        else if (state_reg == ST_EMIT_WR && status.out_free)
        begin
            cmd.emit_load = 1'b1;
            state_next    = status.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/slcd_datapath.sv @@
// ----------------------------------------------------------------------------
// slcd_datapath
// Configuration registers, frame counters, CRC, payload memory and the
// output register of the packet deframer.
// ----------------------------------------------------------------------------
module slcd_datapath #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [slcd_pkg::CFG_AW-1:0]  cfg_index,
    input  logic [slcd_pkg::CFG_DW-1:0]  cfg_data,
    input  logic [slcd_pkg::BYTE_W-1:0]  data_byte,
    input  slcd_pkg::slcd_cmd_t          cmd,
    output slcd_pkg::slcd_status_t       status,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         kind,
    output logic [1:0]                   fault_code,
    output logic [slcd_pkg::BYTE_W-1:0]  payload_byte,
    output logic [slcd_pkg::LEN_W-1:0]   frame_length,
    output logic                         last
);
    import slcd_pkg::*;

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [BYTE_W-1:0] MAX_LEN_B = BYTE_W'(MAX_PAYLOAD);

    logic [BYTE_W-1:0] sync0_reg;
    logic [BYTE_W-1:0] sync1_reg;
    logic [BYTE_W-1:0] sync2_reg;
    logic [BYTE_W-1:0] sync3_reg;
    logic [BYTE_W-1:0] term_reg;
    logic [TICK_W-1:0] timeout_reg;

    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  index_reg;
    logic [LEN_W-1:0]  rd_index_reg;
    logic [CRC_W-1:0]  crc_reg;
    logic [BYTE_W-1:0] rx_crc_hi_reg;
    logic [TICK_W-1:0] tick_reg;

    logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] mem_q_reg;

    logic              out_valid_reg;
    logic              kind_reg;
    logic [1:0]        code_reg;
    logic [BYTE_W-1:0] payload_reg;
    logic [LEN_W-1:0]  flen_reg;
    logic              last_reg;

    logic [TICK_W-1:0] tick_next;
    logic [LEN_W-1:0]  index_next;
    logic [LEN_W-1:0]  rd_index_next;

    assign tick_next     = TICK_W'(tick_reg + 1'b1);
    assign index_next    = LEN_W'(index_reg + 1'b1);
    assign rd_index_next = LEN_W'(rd_index_reg + 1'b1);

    always_comb
    begin
        status.sync0_match = (data_byte == sync0_reg);
        status.sync1_match = (data_byte == sync1_reg);
        status.sync2_match = (data_byte == sync2_reg);
        status.sync3_match = (data_byte == sync3_reg);
        status.term_match  = (data_byte == term_reg);
        status.len_ok      = (data_byte != '0) && (data_byte <= MAX_LEN_B);
        status.crc_ok      = ({rx_crc_hi_reg, data_byte} == crc_reg);
        status.pay_last    = (index_next == length_reg);
        status.timeout_hit = (tick_next == timeout_reg);
        status.emit_last   = (rd_index_next == length_reg);
        status.out_free    = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync0_reg   <= '0;
            sync1_reg   <= '0;
            sync2_reg   <= '0;
            sync3_reg   <= '0;
            term_reg    <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_0:     sync0_reg   <= cfg_data[BYTE_W-1:0];
                REG_SYNC_1:     sync1_reg   <= cfg_data[BYTE_W-1:0];
                REG_SYNC_2:     sync2_reg   <= cfg_data[BYTE_W-1:0];
                REG_SYNC_3:     sync3_reg   <= cfg_data[BYTE_W-1:0];
                REG_TERMINATOR: term_reg    <= cfg_data[BYTE_W-1:0];
                REG_TIMEOUT:    timeout_reg <= cfg_data[TICK_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            index_reg     <= '0;
            rd_index_reg  <= '0;
            crc_reg       <= CRC_INIT;
            rx_crc_hi_reg <= '0;
            tick_reg      <= '0;
        end
        else
        begin
            if (cmd.frame_reset)
            begin
                index_reg     <= '0;
                tick_reg      <= '0;
                crc_reg       <= CRC_INIT;
                rx_crc_hi_reg <= '0;
            end
            else
            begin
                if (cmd.tick)
                begin
                    tick_reg <= tick_next;
                end
                if (cmd.load_len)
                begin
                    length_reg <= data_byte[LEN_W-1:0];
                    index_reg  <= '0;
                    crc_reg    <= CRC_INIT;
                end
                if (cmd.store_byte)
                begin
                    index_reg <= index_next;
                    crc_reg   <= crc_update(crc_reg, data_byte);
                end
                if (cmd.load_crc_hi)
                begin
                    rx_crc_hi_reg <= data_byte;
                end
            end
            if (cmd.emit_start)
            begin
                rd_index_reg <= '0;
            end
            else if (cmd.emit_load)
            begin
                rd_index_reg <= rd_index_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            mem[index_reg[IDX_W-1:0]] <= data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_read)
        begin
            mem_q_reg <= mem[rd_index_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.err_load || cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.err_load)
        begin
            kind_reg    <= 1'b1;
            code_reg    <= cmd.err_code;
            payload_reg <= '0;
            flen_reg    <= '0;
            last_reg    <= 1'b1;
        end
        else if (cmd.emit_load)
        begin
            kind_reg    <= 1'b0;
            code_reg    <= ERR_SYNC;
            payload_reg <= mem_q_reg;
            flen_reg    <= length_reg;
            last_reg    <= status.emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign fault_code   = code_reg;
    assign payload_byte = payload_reg;
    assign frame_length = flen_reg;
    assign last         = last_reg;

endmodule

@@ sv/sync_length_crc_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// sync_length_crc_packet_deframer
// Receives a byte stream framed by four sync bytes, a length byte, a
// CRC-16/CCITT checked payload and a terminator, and delivers payloads.
//
// Each input request carries either a received byte or an idle tick. Framing
// bytes and ticks are taken at one per cycle while the output register is
// free or being emptied. A frame fault produces a single error request in
// the cycle after the offending byte. After a good terminator the payload is
// read back from the on-chip store: each byte is read from memory, then
// loaded into the output register, and the input is held off until the
// last byte has been loaded. When the receiver stalls, the pending result
// stays in the output register and the input is held off until that result
// has been taken. Reset returns the block to idle with the default
// configuration; the payload store needs no clearing. Configuration writes
// take effect at once and should only be made while the block is idle.
// ----------------------------------------------------------------------------
module sync_length_crc_packet_deframer #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [slcd_pkg::CFG_AW-1:0]  cfg_index,
    input  logic [slcd_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         mode,
    input  logic [slcd_pkg::BYTE_W-1:0]  data_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         kind,
    output logic [1:0]                   fault_code,
    output logic [slcd_pkg::BYTE_W-1:0]  payload_byte,
    output logic [slcd_pkg::LEN_W-1:0]   frame_length,
    output logic                         last
);
    import slcd_pkg::*;

    slcd_cmd_t    cmd;
    slcd_status_t status;

    slcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd)
    );

    slcd_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_byte    (data_byte),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .fault_code   (fault_code),
        .payload_byte (payload_byte),
        .frame_length (frame_length),
        .last         (last)
    );

endmodule

@@ sim/deframer_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_frame_checker
// Watches the deframer's configuration port and both request channels. It
// keeps its own copy of the register values and the framing state, works
// out the results that each accepted input request should give, and checks
// every accepted output request field by field against the oldest one due.
// ----------------------------------------------------------------------------
package deframer_tb_pkg;

    localparam logic        MODE_BYTE    = 1'b0;
    localparam logic        MODE_TICK    = 1'b1;
    localparam logic        KIND_PAYLOAD = 1'b0;
    localparam logic        KIND_FAULT   = 1'b1;
    localparam int          PAYLOAD_MAX  = 64;
    localparam logic [15:0] CCITT_POLY   = 16'h1021;

    // Bitwise form of the CRC-16/CCITT byte update.
    function automatic logic [15:0] ccitt_next(input logic [15:0] crc,
                                               input logic [7:0] b);
        logic [15:0] c;
        int          i;
        c = crc ^ {b, 8'h00};
        for (i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ CCITT_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

module deframer_frame_checker
    import slcd_pkg::*, deframer_tb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  cfg_reg_t           cfg_index,
    input  logic [CFG_DW-1:0]  cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               mode,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               kind,
    input  logic [1:0]         fault_code,
    input  logic [BYTE_W-1:0]  payload_byte,
    input  logic [LEN_W-1:0]   frame_length,
    input  logic               last,
    output int                 mismatches,
    output int                 pending,
    output int                 requests_seen,
    output int                 results_seen,
    output int                 frames_predicted,
    output int                 faults_predicted
);

    typedef enum logic [3:0] {
        ST_HUNT, ST_SYNC_1, ST_SYNC_2, ST_SYNC_3, ST_LEN,
        ST_BODY, ST_FCS_HI, ST_FCS_LO, ST_END
    } rx_state_t;

    typedef struct {
        logic              kind;
        err_code_t         code;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              last;
    } deframer_result_t;

    deframer_result_t  results_due[$];

    logic [BYTE_W-1:0] sync_cfg [4];
    logic [BYTE_W-1:0] term_cfg;
    logic [TICK_W-1:0] timeout_cfg;

    rx_state_t         rx_state;
    logic [LEN_W-1:0]  len_due;
    logic [LEN_W-1:0]  body_index;
    logic [BYTE_W-1:0] body_store [PAYLOAD_MAX];
    logic [CRC_W-1:0]  fcs_running;
    logic [CRC_W-1:0]  fcs_received;
    logic [TICK_W-1:0] tick_total;

    task automatic restart_frame();
        rx_state     = ST_HUNT;
        body_index   = '0;
        tick_total   = '0;
        fcs_running  = CRC_INIT;
        fcs_received = '0;
    endtask

    task automatic expect_fault(input err_code_t code);
        deframer_result_t r;
        r.kind = KIND_FAULT;
        r.code = code;
        r.data = '0;
        r.len  = '0;
        r.last = 1'b1;
        results_due.push_back(r);
        faults_predicted++;
        restart_frame();
    endtask

    task automatic expect_delivery();
        deframer_result_t r;
        int               k;
        for (k = 0; k < len_due; k++)
        begin
            r.kind = KIND_PAYLOAD;
            // The code field reads as zero on payload bytes.
            r.code = ERR_SYNC;
            r.data = body_store[k];
            r.len  = len_due;
            r.last = (k == len_due - 1);
            results_due.push_back(r);
        end
        frames_predicted++;
        restart_frame();
    endtask

    task automatic predict_request(input logic m, input logic [BYTE_W-1:0] b);
        if (m == MODE_TICK)
        begin
            tick_total = tick_total + 1'b1;
            if (tick_total == timeout_cfg)
                restart_frame();
        end
        else
        begin
            case (rx_state)
                ST_SYNC_1:
                    if (b != sync_cfg[1]) expect_fault(ERR_SYNC);
                    else rx_state = ST_SYNC_2;
                ST_SYNC_2:
                    if (b != sync_cfg[2]) expect_fault(ERR_SYNC);
                    else rx_state = ST_SYNC_3;
                ST_SYNC_3:
                    if (b != sync_cfg[3]) expect_fault(ERR_SYNC);
                    else rx_state = ST_LEN;
                ST_LEN:
                    if (b == 0 || b > PAYLOAD_MAX)
                        expect_fault(ERR_LENGTH);
                    else
                    begin
                        len_due     = b[LEN_W-1:0];
                        body_index  = '0;
                        fcs_running = CRC_INIT;
                        rx_state    = ST_BODY;
                    end
                ST_BODY:
                begin
                    body_store[body_index[5:0]] = b;
                    fcs_running = ccitt_next(fcs_running, b);
                    body_index  = body_index + 1'b1;
                    if (body_index >= len_due)
                        rx_state = ST_FCS_HI;
                end
                ST_FCS_HI:
                begin
                    fcs_received = {b, 8'h00};
                    rx_state     = ST_FCS_LO;
                end
                ST_FCS_LO:
                begin
                    fcs_received[7:0] = b;
                    if (fcs_received != fcs_running) expect_fault(ERR_CRC);
                    else rx_state = ST_END;
                end
                ST_END:
                    if (b != term_cfg) expect_fault(ERR_TERM);
                    else expect_delivery();
                default:
                    rx_state = (b == sync_cfg[0]) ? ST_SYNC_1 : ST_HUNT;
            endcase
        end
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        deframer_result_t r;
        results_seen++;
        if (results_due.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, got kind %0h code %0h",
                     $time, kind, fault_code);
            $display("%0t:   byte %0h length %0h last %0h",
                     $time, payload_byte, frame_length, last);
            mismatches++;
        end
        else
        begin
            r = results_due.pop_front();
            compare_field("kind", 8'(r.kind), 8'(kind));
            compare_field("fault_code", 8'(r.code), 8'(fault_code));
            compare_field("payload_byte", r.data, payload_byte);
            compare_field("frame_length", 8'(r.len), 8'(frame_length));
            compare_field("last", 8'(r.last), 8'(last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_due.delete();
            sync_cfg         = '{default: '0};
            term_cfg         = '0;
            timeout_cfg      = TIMEOUT_RESET;
            len_due          = '0;
            mismatches       = 0;
            requests_seen    = 0;
            results_seen     = 0;
            frames_predicted = 0;
            faults_predicted = 0;
            restart_frame();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SYNC_0:     sync_cfg[0] = cfg_data[7:0];
                    REG_SYNC_1:     sync_cfg[1] = cfg_data[7:0];
                    REG_SYNC_2:     sync_cfg[2] = cfg_data[7:0];
                    REG_SYNC_3:     sync_cfg[3] = cfg_data[7:0];
                    REG_TERMINATOR: term_cfg    = cfg_data[7:0];
                    REG_TIMEOUT:    timeout_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
            begin
                requests_seen++;
                predict_request(mode, data_byte);
            end
            pending <= results_due.size();
        end
    end

endmodule

@@ sim/sync_length_crc_packet_deframer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_crc_packet_deframer_test
// Drives the packet deframer with framed byte streams and idle ticks under
// several register settings and idling patterns; the checker beside the
// block predicts every result and this module gives the verdict.
// ----------------------------------------------------------------------------
module sync_length_crc_packet_deframer_test;

    import slcd_pkg::*;
    import deframer_tb_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_SLACK = 8;
    localparam int TAIL_CYCLES = 2 * PAYLOAD_MAX + 16;
    localparam int PHASE_ITEMS = 120;

    typedef enum int {
        FLAW_NONE, FLAW_SYNC, FLAW_LENGTH, FLAW_CRC, FLAW_TERM, FLAW_CUT
    } frame_flaw_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cfg_we     = 1'b0;
    cfg_reg_t          cfg_index  = REG_SYNC_0;
    logic [CFG_DW-1:0] cfg_data   = '0;
    logic              in_valid   = 1'b0;
    logic              mode       = MODE_BYTE;
    logic [BYTE_W-1:0] data_byte  = '0;
    logic              out_ready  = 1'b0;
    logic              in_ready;
    logic              out_valid;
    logic              kind;
    logic [1:0]        fault_code;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  frame_length;
    logic              last;

    int mismatches, pending, requests_seen, results_seen;
    int frames_predicted, faults_predicted;

    int                sender_idle_pct    = 0;
    int                receiver_stall_pct = 0;
    int                frame_items        = 0;
    int                quiet_cycles       = 0;
    logic [BYTE_W-1:0] sync_set [4];
    logic [BYTE_W-1:0] term_set;
    logic [BYTE_W-1:0] payload_q [$];

    sync_length_crc_packet_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .fault_code   (fault_code),
        .payload_byte (payload_byte),
        .frame_length (frame_length),
        .last         (last)
    );

    deframer_frame_checker frame_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .fault_code       (fault_code),
        .payload_byte     (payload_byte),
        .frame_length     (frame_length),
        .last             (last),
        .mismatches       (mismatches),
        .pending          (pending),
        .requests_seen    (requests_seen),
        .results_seen     (results_seen),
        .frames_predicted (frames_predicted),
        .faults_predicted (faults_predicted)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    task automatic load_settings(input logic [7:0] s0, s1, s2, s3, t,
                                 input logic [15:0] limit);
        sync_set = '{s0, s1, s2, s3};
        term_set = t;
        write_reg(REG_SYNC_0, 16'(s0));
        write_reg(REG_SYNC_1, 16'(s1));
        write_reg(REG_SYNC_2, 16'(s2));
        write_reg(REG_SYNC_3, 16'(s3));
        write_reg(REG_TERMINATOR, 16'(t));
        write_reg(REG_TIMEOUT, limit);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Entered and left just after a rising edge; leaves once the request is taken.
    task automatic send_item(input logic m, input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Sends the frame around payload_q, spoilt as the flaw says, with ticks
    // scattered between its bytes.
    task automatic send_frame(input frame_flaw_t flaw, input int tick_pct);
        logic [BYTE_W-1:0] stream [$];
        logic [CRC_W-1:0]  fcs;
        int                n, j, stop;
        n   = payload_q.size();
        fcs = CRC_INIT;
        for (j = 0; j < 4; j++)
            stream.push_back(sync_set[j]);
        stream.push_back(8'(n));
        for (j = 0; j < n; j++)
        begin
            stream.push_back(payload_q[j]);
            fcs = ccitt_next(fcs, payload_q[j]);
        end
        stream.push_back(fcs[15:8]);
        stream.push_back(fcs[7:0]);
        stream.push_back(term_set);
        stop = n + 8;
        case (flaw)
            FLAW_SYNC:
            begin
                j = $urandom_range(3);
                stream[j] ^= 8'($urandom_range(255, 1));
                stop = j + 1;
            end
            FLAW_LENGTH:
            begin
                stream[4] = $urandom_range(1) ? 8'h00
                                              : 8'($urandom_range(255, PAYLOAD_MAX + 1));
                stop = 5;
            end
            FLAW_CRC:
            begin
                stream[5 + n + $urandom_range(1)] ^= 8'($urandom_range(255, 1));
                stop = n + 7;
            end
            FLAW_TERM:
                stream[n + 7] ^= 8'($urandom_range(255, 1));
            FLAW_CUT:
                stop = $urandom_range(n + 7, 1);
            default: ;
        endcase
        for (j = 0; j < stop; j++)
        begin
            if ($urandom_range(99) < tick_pct)
            begin
                send_item(MODE_TICK, 8'($urandom));
                frame_items++;
            end
            send_item(MODE_BYTE, stream[j]);
            frame_items++;
        end
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return PAYLOAD_MAX;
        if (r < 20)
            return $urandom_range(PAYLOAD_MAX - 1, 9);
        return $urandom_range(8, 1);
    endfunction

    function automatic frame_flaw_t pick_flaw();
        if ($urandom_range(99) < 45)
            return FLAW_NONE;
        return frame_flaw_t'($urandom_range(FLAW_CUT, FLAW_SYNC));
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int start, len;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start = frame_items;
        while (frame_items - start < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 75)
            begin
                len = pick_length();
                payload_q.delete();
                repeat (len) payload_q.push_back(8'($urandom));
                send_frame(pick_flaw(), 4);
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    send_item($urandom_range(1) ? MODE_TICK : MODE_BYTE, 8'($urandom));
            end
            if ($urandom_range(24) == 0)
                hold_until_drained();
        end
    endtask

    initial
    begin
        int k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        load_settings(8'hAA, 8'h55, 8'h00, 8'hFF, 8'h7E, 16'hFFFF);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_TICK, 8'hFF);
        send_item(MODE_BYTE, 8'hAA);
        send_item(MODE_BYTE, 8'h00);
        for (k = 0; k < 4; k++)
            send_item(MODE_BYTE, sync_set[k]);
        send_item(MODE_BYTE, 8'h00);
        payload_q = {8'hFF};
        send_frame(FLAW_NONE, 0);
        payload_q = {8'h00};
        send_frame(FLAW_CRC, 0);
        hold_until_drained();

        load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd1);
        run_phase(0, 0);
        hold_until_drained();

        load_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF);
        run_phase(56, 0);
        hold_until_drained();

        load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 16'($urandom_range(40, 2)));
        run_phase(0, 56);
        hold_until_drained();

        load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 16'd3);
        run_phase(21, 21);
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d input requests under five register settings",
                 requests_seen);
        $display("and four idling patterns: %0d frames delivered, %0d fault reports, %0d results.",
                 frames_predicted, faults_predicted, results_seen);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
